>>> rtl/nfc_pkg.sv
// nfc_pkg: shared types, field codes and sentence offsets for the nmea field capture unit
// used by nfc_ctrl, nfc_datapath and the top level; depends on nothing else
package nfc_pkg;

  // emitted field codes
  localparam logic [2:0] FLD_DATE = 3'd0;
  localparam logic [2:0] FLD_TIME = 3'd1;
  localparam logic [2:0] FLD_LAT  = 3'd2;
  localparam logic [2:0] FLD_LNG  = 3'd3;
  localparam logic [2:0] FLD_ALT  = 3'd4;

  // characters of interest
  localparam logic [7:0] CHR_COMMA = 8'h2C;
  localparam logic [7:0] CHR_ZERO  = 8'h30;

  // sentence headers, first byte at index 0
  localparam logic [7:0] HDR_GGA [6] = '{8'h24, 8'h47, 8'h50, 8'h47, 8'h47, 8'h41};
  localparam logic [7:0] HDR_RMC [6] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43};

  // byte positions within a line
  localparam logic [6:0] HDR_END      = 7'd5;
  localparam logic [6:0] TIME_POS     = 7'd7;
  localparam logic [6:0] TIME_END     = 7'd16;
  localparam logic [6:0] LAT_POS      = 7'd20;
  localparam logic [6:0] LAT_END      = 7'd28;
  localparam logic [6:0] LAT_HEMI_POS = 7'd30;
  localparam logic [6:0] LNG_POS      = 7'd32;
  localparam logic [6:0] LNG_END      = 7'd41;
  localparam logic [6:0] LNG_HEMI_POS = 7'd43;
  localparam logic [6:0] ALT_POS      = 7'd52;
  localparam logic [6:0] ALT_END      = 7'd57;
  localparam logic [6:0] DATE_POS     = 7'd57;
  localparam logic [6:0] DATE_END     = 7'd62;
  localparam logic [6:0] POS_MAX      = 7'd127;

  // controller to datapath
  typedef struct packed {
    logic accept;   // store the byte of an accepted item
    logic commit;   // copy captured fields into the records at line end
    logic load;     // move the next character into the output register
  } nfc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic emit_go;     // date and time held once this commit is done
    logic out_free;    // output register can take a character this cycle
    logic final_char;  // character being loaded closes the run
  } nfc_stat_t;

  // index of the final character of each field
  function automatic logic [3:0] fld_last(input logic [2:0] fid);
    logic [3:0] r;
    unique case (fid)
      FLD_DATE: r = 4'd5;
      FLD_TIME: r = 4'd9;
      FLD_LAT:  r = 4'd9;
      FLD_LNG:  r = 4'd10;
      FLD_ALT:  r = 4'd5;
      default:  r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/nmea_fixed_offset_field_capture_unit.sv
// nmea_fixed_offset_field_capture_unit: top level of the nmea field capture block
// depends on nfc_pkg, nfc_ctrl and nfc_datapath
//
// Usage:
// - input channel in_*: one sentence byte per item in in_tdata, in_tlast on the
//   final byte of a line; byte 0 of a line is the byte after the previous in_tlast
// - bytes inside a line are taken one per cycle; position saturates at 127
// - at a line end the block checks the header in its commit state and copies
//   time, date, latitude, longitude and altitude from their fixed offsets
// - once date and time are held, every line end sends the held fields on the
//   out_* channel, one character per item, in order date, time, latitude,
//   longitude, altitude, with out_tlast on the final character (16 to 43 items)
// - emission runs at one item per cycle while out_tready is high, from the emission
//   pointer into a single output register; in_tready is low from the line end until
//   the final character is loaded
// - a stalled receiver holds the output register and pauses emission; the next
//   line may start while the final character still waits
// - reset clears the position, the held flags and the output valid; records
//   are empty until captured and are never sent before then
module nmea_fixed_offset_field_capture_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tlast,   // line_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // char_code
  output logic [2:0]  out_tuser,  // field_id
  output logic        out_tlast   // last
);
  import nfc_pkg::*;

  nfc_cmd_t  cmd;
  nfc_stat_t st;

  // sequencer
  nfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  // capture, records and output register
  nfc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .st         (st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> rtl/nfc_ctrl.sv
// nfc_ctrl: state machine for receive, commit and character emission
// depends on nfc_pkg for the command and status structs
module nfc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tlast,
  output logic                in_tready,
  input  nfc_pkg::nfc_stat_t  st,
  output nfc_pkg::nfc_cmd_t   cmd
);
  import nfc_pkg::*;

  typedef enum logic [2:0] {
    S_RECV   = 3'b001,
    S_COMMIT = 3'b010,
    S_EMIT   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state_r)
      S_RECV: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = st.emit_go ? S_EMIT : S_RECV;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.load = 1'b1;
          if (st.final_char) begin
            state_nxt = S_RECV;
          end
        end
      end
      default: state_nxt = S_RECV;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/nfc_datapath.sv
// nfc_datapath: byte position, field capture, held records and output register
// depends on nfc_pkg; driven by nfc_ctrl through command and status structs
module nfc_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  nfc_pkg::nfc_cmd_t   cmd,
  output nfc_pkg::nfc_stat_t  st,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,   // char_code
  output logic [2:0]          out_tuser,   // field_id
  output logic                out_tlast
);
  import nfc_pkg::*;

  logic [6:0] pos_r;
  logic [6:0] end_pos_r;

  // bytes captured from the current line
  logic [7:0] cand_hdr  [6];
  logic [7:0] cand_time [10];
  logic [7:0] cand_lat  [10];
  logic [7:0] cand_lng  [11];
  logic [7:0] cand_alt  [6];
  logic [7:0] cand_date [6];

  // held records
  logic [7:0] rec_time [10];
  logic [7:0] rec_lat  [10];
  logic [7:0] rec_lng  [11];
  logic [7:0] rec_alt  [6];
  logic [7:0] rec_date [6];
  logic [4:0] held_r, held_nxt;

  // emission pointer and output register
  logic [2:0] fid_r;
  logic [3:0] cidx_r;
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic [2:0] out_fid_r;
  logic       out_last_r;

  logic [6:0] off_time, off_lat, off_lng, off_alt, off_date;
  logic       is_gga, is_rmc, lat_zero, lng_zero, alt_comma;
  logic       take_time, take_lat, take_lng, take_date, take_alt;
  logic       nxt_found;
  logic [2:0] nxt_fid;
  logic [7:0] cur_char;
  logic       at_field_end;

  assign off_time = pos_r - TIME_POS;
  assign off_lat  = pos_r - LAT_POS;
  assign off_lng  = pos_r - LNG_POS;
  assign off_alt  = pos_r - ALT_POS;
  assign off_date = pos_r - DATE_POS;

  // position counter, saturating, back to zero after a line end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.accept) begin
      if (in_last) begin
        pos_r <= '0;
      end else if (pos_r != POS_MAX) begin
        pos_r <= pos_r + 7'd1;
      end
    end
  end

  // capture bytes at their fixed offsets
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      end_pos_r <= pos_r;
      if (pos_r <= HDR_END) begin
        cand_hdr[pos_r[2:0]] <= in_byte;
      end
      if (pos_r >= TIME_POS && pos_r <= TIME_END) begin
        cand_time[off_time[3:0]] <= in_byte;
      end
      if (pos_r >= LAT_POS && pos_r <= LAT_END) begin
        cand_lat[off_lat[3:0]] <= in_byte;
      end
      if (pos_r == LAT_HEMI_POS) begin
        cand_lat[9] <= in_byte;
      end
      if (pos_r >= LNG_POS && pos_r <= LNG_END) begin
        cand_lng[off_lng[3:0]] <= in_byte;
      end
      if (pos_r == LNG_HEMI_POS) begin
        cand_lng[10] <= in_byte;
      end
      if (pos_r >= ALT_POS && pos_r <= ALT_END) begin
        cand_alt[off_alt[2:0]] <= in_byte;
      end
      if (pos_r >= DATE_POS && pos_r <= DATE_END) begin
        cand_date[off_date[2:0]] <= in_byte;
      end
    end
  end

  // line type and field checks at line end
  always_comb begin
    is_gga = (end_pos_r >= HDR_END);
    is_rmc = (end_pos_r >= HDR_END);
    for (int i = 0; i < 6; i++) begin
      if (cand_hdr[i] != HDR_GGA[i]) is_gga = 1'b0;
      if (cand_hdr[i] != HDR_RMC[i]) is_rmc = 1'b0;
    end
    alt_comma = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (cand_alt[i] == CHR_COMMA) alt_comma = 1'b1;
    end
    lat_zero = (cand_lat[0] == CHR_ZERO) && (cand_lat[1] == CHR_ZERO) &&
               (cand_lat[2] == CHR_ZERO) && (cand_lat[3] == CHR_ZERO);
    lng_zero = (cand_lng[0] == CHR_ZERO) && (cand_lng[1] == CHR_ZERO) &&
               (cand_lng[2] == CHR_ZERO) && (cand_lng[3] == CHR_ZERO);
    take_alt  = is_gga && (end_pos_r >= ALT_END) && !alt_comma;
    take_time = is_rmc && (end_pos_r >= TIME_END);
    take_lat  = is_rmc && (end_pos_r >= LAT_HEMI_POS) && !lat_zero;
    take_lng  = is_rmc && (end_pos_r >= LNG_HEMI_POS) && !lng_zero;
    take_date = is_rmc && (end_pos_r >= DATE_END);
    held_nxt  = held_r | {take_alt, take_lng, take_lat, take_time, take_date};
  end

  // records and held flags
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (take_time) rec_time <= cand_time;
      if (take_lat)  rec_lat  <= cand_lat;
      if (take_lng)  rec_lng  <= cand_lng;
      if (take_alt)  rec_alt  <= cand_alt;
      if (take_date) rec_date <= cand_date;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (cmd.commit) begin
      held_r <= held_nxt;
    end
  end

  // next held field after the current one
  always_comb begin
    nxt_found = 1'b0;
    nxt_fid   = fid_r;
    for (int k = 4; k > 0; k--) begin
      if (3'(k) > fid_r && held_r[k]) begin
        nxt_found = 1'b1;
        nxt_fid   = 3'(k);
      end
    end
  end

  // character under the emission pointer
  always_comb begin
    unique case (fid_r)
      FLD_DATE: cur_char = rec_date[cidx_r[2:0]];
      FLD_TIME: cur_char = rec_time[cidx_r];
      FLD_LAT:  cur_char = rec_lat[cidx_r];
      FLD_LNG:  cur_char = rec_lng[cidx_r];
      FLD_ALT:  cur_char = rec_alt[cidx_r[2:0]];
      default:  cur_char = '0;
    endcase
  end

  assign at_field_end  = (cidx_r == fld_last(fid_r));
  assign st.emit_go    = held_nxt[FLD_DATE] && held_nxt[FLD_TIME];
  assign st.out_free   = !out_valid_r || out_tready;
  assign st.final_char = at_field_end && !nxt_found;

  // emission pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fid_r  <= FLD_DATE;
      cidx_r <= '0;
    end else if (cmd.commit) begin
      fid_r  <= FLD_DATE;
      cidx_r <= '0;
    end else if (cmd.load) begin
      if (at_field_end) begin
        fid_r  <= nxt_fid;
        cidx_r <= '0;
      end else begin
        cidx_r <= cidx_r + 4'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= cur_char;
      out_fid_r  <= fid_r;
      out_last_r <= at_field_end && !nxt_found;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_fid_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // a character is never loaded over one still waiting
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_tready))
    else $error("character loaded over a waiting one");

  // emission only runs with date and time held
  a_load_held: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (held_r[FLD_DATE] && held_r[FLD_TIME]))
    else $error("emission without date and time held");

  // pointer stays inside a valid field
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (fid_r <= FLD_ALT && cidx_r <= fld_last(fid_r)))
    else $error("emission pointer out of range");

  // no byte taken while a line is being committed or emitted
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !(cmd.commit || cmd.load))
    else $error("byte accepted during commit or emission");
`endif

endmodule
